[src/pfns_pkg.sv]
package pfns_pkg;

  localparam int unsigned LEVELS = 4;
  localparam logic [15:0] CUTOFF_RESET = 16'd200;
  localparam logic [15:0] CLOCK_MAX = 16'hFFFF;

  localparam logic [2:0] ST_ACCEPT = 3'd0;
  localparam logic [2:0] ST_DROP   = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;
  localparam logic [2:0] ST_HALT   = 3'd5;

  localparam logic ACT_ARRIVAL = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic REG_CUTOFF = 1'b0;

  typedef struct packed {
    logic       action;
    logic [7:0] job_id;
    logic [2:0] job_priority;
    logic [7:0] service_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  running_id;
    logic [15:0] time_now;
    logic [15:0] first_run_time;
    logic        just_started;
  } out_item_t;

  typedef struct packed {
    logic       tick;
    logic       prio_ok;
    logic [1:0] level;
    logic [7:0] job_id;
    logic [7:0] service_time;
  } fe_item_t;

  typedef struct packed {
    logic     valid;
    fe_item_t item;
  } fe_link_t;

endpackage

[src/pfns_ram.sv]
module pfns_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/pfns_front.sv]
module pfns_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pfns_pkg::in_item_t  in_data,
  output logic                full,
  output pfns_pkg::fe_link_t  fe,
  input  logic                fe_pop
);

  pfns_pkg::fe_item_t buf_r [2];
  logic [1:0]         cnt_r, cnt_nxt;
  logic               wp_r, rp_r;
  logic               wr, rd;
  pfns_pkg::fe_item_t cls;

  always_comb begin
    cls.tick         = (in_data.action == pfns_pkg::ACT_TICK);
    cls.prio_ok      = (in_data.job_priority >= 3'd1) && (in_data.job_priority <= 3'd4);
    cls.level        = 2'(in_data.job_priority - 3'd1);
    cls.job_id       = in_data.job_id;
    cls.service_time = in_data.service_time;
  end

  assign full = (cnt_r == 2'd2);
  assign wr   = push && !full;
  assign rd   = fe_pop && (cnt_r != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      buf_r[wp_r] <= cls;
    end
  end

  assign fe.valid = (cnt_r != 2'd0);
  assign fe.item  = buf_r[rp_r];

endmodule

[src/pfns_back.sv]
module pfns_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [15:0]         cutoff,
  input  pfns_pkg::fe_link_t  fe,
  output logic                fe_pop,
  output logic                empty,
  input  logic                pop,
  output pfns_pkg::out_item_t out_data
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W = 2 + PTR_W;
  localparam int unsigned MEM_D  = 1 << ADDR_W;

  typedef enum logic [1:0] {
    S_EXEC = 2'b01,
    S_DISP = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r [4];
  logic [CNT_W-1:0]    cnt_nxt [4];
  logic [PTR_W-1:0]    hd_r [4];
  logic [PTR_W-1:0]    hd_nxt [4];
  logic [PTR_W-1:0]    tl_r [4];
  logic [PTR_W-1:0]    tl_nxt [4];
  logic                busy_r, busy_nxt;
  logic [7:0]          cur_r, cur_nxt;
  logic [7:0]          ql_r, ql_nxt;
  logic [15:0]         start_r, start_nxt;
  logic [15:0]         clock_r, clock_nxt;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [15:0]         ram_wdata, ram_rdata;

  logic                found;
  logic [1:0]          sel_q;
  logic                ospace;
  logic                res_vld;
  pfns_pkg::out_item_t res;
  logic                do_run, run_started, run_fin;
  logic [7:0]          run_id, run_ql;
  logic [15:0]         run_start;
  logic [15:0]         clock_inc;

  pfns_pkg::out_item_t obuf_r [2];
  logic [1:0]          ocnt_r, ocnt_nxt;
  logic                owp_r, orp_r;
  logic                ord;

  pfns_ram #(
    .WIDTH (16),
    .DEPTH (MEM_D)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    found = 1'b0;
    sel_q = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        found = 1'b1;
        sel_q = 2'(i);
      end
    end
  end

  assign ospace    = (ocnt_r != 2'd2);
  assign clock_inc = (clock_r != pfns_pkg::CLOCK_MAX) ? clock_r + 16'd1 : clock_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    hd_nxt      = hd_r;
    tl_nxt      = tl_r;
    busy_nxt    = busy_r;
    cur_nxt     = cur_r;
    ql_nxt      = ql_r;
    start_nxt   = start_r;
    clock_nxt   = clock_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = {fe.item.level, tl_r[fe.item.level]};
    ram_wdata   = {fe.item.job_id, fe.item.service_time};
    ram_raddr   = {sel_q, hd_r[sel_q]};
    fe_pop      = 1'b0;
    res_vld     = 1'b0;
    res         = '0;
    do_run      = 1'b0;
    run_started = 1'b0;
    run_id      = cur_r;
    run_ql      = ql_r;
    run_start   = start_r;
    run_fin     = 1'b0;

    unique case (state_r)
      S_EXEC: begin
        if (fe.valid && ospace) begin
          fe_pop = 1'b1;
          res.time_now = clock_r;
          if (!fe.item.tick) begin
            res_vld = 1'b1;
            res.running_id = fe.item.job_id;
            if (!fe.item.prio_ok ||
                cnt_r[fe.item.level] == CNT_W'(QUEUE_DEPTH)) begin
              res.status = pfns_pkg::ST_DROP;
            end else begin
              res.status = pfns_pkg::ST_ACCEPT;
              ram_we = 1'b1;
              tl_nxt[fe.item.level] = (tl_r[fe.item.level] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                      '0 : tl_r[fe.item.level] + PTR_W'(1);
              cnt_nxt[fe.item.level] = cnt_r[fe.item.level] + CNT_W'(1);
            end
          end else if (busy_r) begin
            do_run = 1'b1;
          end else if (clock_r >= cutoff) begin
            res_vld    = 1'b1;
            res.status = pfns_pkg::ST_HALT;
          end else if (found) begin
            ram_re        = 1'b1;
            hd_nxt[sel_q] = (hd_r[sel_q] == PTR_W'(QUEUE_DEPTH - 1)) ?
                            '0 : hd_r[sel_q] + PTR_W'(1);
            cnt_nxt[sel_q] = cnt_r[sel_q] - CNT_W'(1);
            state_nxt     = S_DISP;
          end else begin
            res_vld    = 1'b1;
            res.status = pfns_pkg::ST_IDLE;
            clock_nxt  = clock_inc;
          end
        end
      end
      S_DISP: begin
        if (ospace) begin
          do_run      = 1'b1;
          run_started = 1'b1;
          run_id      = ram_rdata[15:8];
          run_ql      = ram_rdata[7:0];
          run_start   = clock_r;
          state_nxt   = S_EXEC;
        end
      end
      default: begin
        state_nxt = S_EXEC;
      end
    endcase

    if (do_run) begin
      run_fin            = (run_ql <= 8'd1);
      ql_nxt             = (run_ql == 8'd0) ? 8'd0 : run_ql - 8'd1;
      busy_nxt           = !run_fin;
      cur_nxt            = run_id;
      start_nxt          = run_start;
      clock_nxt          = clock_inc;
      res_vld            = 1'b1;
      res.status         = run_fin ? pfns_pkg::ST_FINISH : pfns_pkg::ST_RUN;
      res.running_id     = run_id;
      res.time_now       = clock_r;
      res.first_run_time = run_start;
      res.just_started   = run_started;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EXEC;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
        hd_r[i]  <= '0;
        tl_r[i]  <= '0;
      end
      busy_r  <= 1'b0;
      cur_r   <= 8'd0;
      ql_r    <= 8'd0;
      start_r <= 16'd0;
      clock_r <= 16'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hd_r    <= hd_nxt;
      tl_r    <= tl_nxt;
      busy_r  <= busy_nxt;
      cur_r   <= cur_nxt;
      ql_r    <= ql_nxt;
      start_r <= start_nxt;
      clock_r <= clock_nxt;
    end
  end

  // result buffer
  assign ord = pop && (ocnt_r != 2'd0);

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (res_vld && !ord) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (ord && !res_vld) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (res_vld) begin
        owp_r <= ~owp_r;
      end
      if (ord) begin
        orp_r <= ~orp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      obuf_r[owp_r] <= res;
    end
  end

  assign empty    = (ocnt_r == 2'd0);
  assign out_data = obuf_r[orp_r];

  a_disp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DISP |-> !busy_r)
    else $error("dispatch while a job is running");

  a_read_disp: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> state_r == S_DISP)
    else $error("store read not followed by dispatch");

  a_obuf_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> ocnt_r != 2'd2)
    else $error("result written into full buffer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CNT_W'(QUEUE_DEPTH) && cnt_r[1] <= CNT_W'(QUEUE_DEPTH) &&
    cnt_r[2] <= CNT_W'(QUEUE_DEPTH) && cnt_r[3] <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

[src/priority_fifo_nonpreemptive_scheduler_unit.sv]
// Path: the result of a transaction accepted on push is registered in the front-end buffer,
// then in the result buffer; a tick that dispatches a new job adds one registered store read.
// Throughput: one item per cycle for arrivals and ticks of a running job while the result
// buffer has room; a dispatching tick holds the back end in its dispatch state for the store read.
// Reset (rst_n low, synchronous): queues empty, no job running, time 0, cutoff 200;
// queue store contents are not cleared.
module priority_fifo_nonpreemptive_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pfns_pkg::in_item_t  in_data,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output pfns_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [15:0]        cutoff_r;
  logic               cfg_wr;
  pfns_pkg::fe_link_t fe;
  logic               fe_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= pfns_pkg::CUTOFF_RESET;
    end else if (cfg_wr && paddr[2] == pfns_pkg::REG_CUTOFF) begin
      cutoff_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == pfns_pkg::REG_CUTOFF) ? {16'd0, cutoff_r} : 32'd0;

  pfns_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .fe      (fe),
    .fe_pop  (fe_pop)
  );

  pfns_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cutoff   (cutoff_r),
    .fe       (fe),
    .fe_pop   (fe_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
